@@ hw/rtl/bda_pkg.sv @@
// Shared types and constants for the block decimating average.
// No dependencies.
package bda_pkg;

  localparam int SampleW = 15;
  localparam int CountW  = 8;
  localparam int ProdW   = 16;
  localparam int SumW    = 23;
  localparam int IndexW  = 2;

  localparam logic [IndexW-1:0] CfgSampleCount = 2'd0;
  localparam logic [IndexW-1:0] CfgGroupCount  = 2'd1;

  typedef struct packed {
    logic [CountW-1:0] len;
    logic [CountW-1:0] cnt;
  } blk_cfg_t;

  typedef struct packed {
    logic              valid;
    logic [SumW-1:0]   dividend;
    logic [CountW-1:0] divisor;
    logic              last;
  } div_req_t;

endpackage

@@ hw/rtl/block_decimating_average.sv @@
// Top level of the block decimating average: config registers, output register.
// Depends on bda_pkg, bda_accum and bda_div.
//
// Usage: samples enter on in_valid/in_stall, one word per accepted sample.
// A block of sample_count samples yields group_count rounded averages on
// out_valid/out_stall; block_last marks the last average of a block.
// A sample that does not close a group keeps the divider idle and the next sample
// can follow right away. A sample that closes a group starts a bit-serial
// division of the group sum by its size, one quotient bit per cycle;
// in_stall stays high until that quotient is handed to the output register,
// from which its average can be taken. The divider sets the rate.
// The output register frees the divider as soon as it is empty, so a new
// sample can be taken while an average still waits downstream. If out_stall
// holds the output register full, a finished quotient waits in the divider
// and in_stall stays high.
// Config writes (cfg_valid/cfg_ready, always ready) to a count restart the block.
// Reset sets both counts to 1, clears all counters and empties the output.
module block_decimating_average #(
  parameter int MAX_BLOCK = 255
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bda_pkg::SampleW-1:0]   sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bda_pkg::SampleW-1:0]   average,
  output logic                          block_last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bda_pkg::IndexW-1:0]    cfg_index,
  input  logic [bda_pkg::CountW-1:0]    cfg_data
);
  import bda_pkg::*;

  localparam logic [CountW-1:0] MaxLen = CountW'(MAX_BLOCK);

  logic [CountW-1:0] sample_count;
  logic [CountW-1:0] group_count;
  logic [CountW-1:0] len_lo;
  logic [CountW-1:0] cnt_lo;
  blk_cfg_t          cfg;
  logic              restart;
  logic              take;
  div_req_t          req;
  logic              div_busy;
  logic              div_done;
  logic [SampleW-1:0] div_q;
  logic              div_last;
  logic              load_out;

  always_comb begin
    len_lo  = (sample_count == '0) ? CountW'(1) : sample_count;
    cfg.len = (len_lo > MaxLen) ? MaxLen : len_lo;
    cnt_lo  = (group_count == '0) ? CountW'(1) : group_count;
    cfg.cnt = (cnt_lo > cfg.len) ? cfg.len : cnt_lo;
  end

  assign cfg_ready = 1'b1;
  assign restart   = cfg_valid && cfg_ready &&
                     (cfg_index == CfgSampleCount || cfg_index == CfgGroupCount);
  assign in_stall  = div_busy;
  assign take      = in_valid && !in_stall;
  assign load_out  = div_done && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= CountW'(1);
      group_count  <= CountW'(1);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CfgSampleCount) begin
        sample_count <= cfg_data;
      end else if (cfg_index == CfgGroupCount) begin
        group_count <= cfg_data;
      end
    end
  end

  bda_accum u_accum (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .restart (restart),
    .take    (take),
    .sample  (sample),
    .req     (req)
  );

  bda_div u_div (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .take_result (load_out),
    .busy        (div_busy),
    .done        (div_done),
    .quotient    (div_q),
    .last        (div_last)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      average    <= div_q;
      block_last <= div_last;
    end
  end

endmodule

@@ hw/rtl/bda_accum.sv @@
// Group bookkeeping: running sum, size, progress and threshold.
// Depends on bda_pkg.
module bda_accum (
  input  logic                     clk,
  input  logic                     rst,
  input  bda_pkg::blk_cfg_t        cfg,
  input  logic                     restart,
  input  logic                     take,
  input  logic [bda_pkg::SampleW-1:0] sample,
  output bda_pkg::div_req_t        req
);
  import bda_pkg::*;

  logic [CountW-1:0] idx;
  logic [ProdW-1:0]  prod;
  logic [ProdW-1:0]  thr_acc;
  logic [SumW-1:0]   sum;
  logic [CountW-1:0] size;

  logic [CountW-1:0] idx_next;
  logic [ProdW-1:0]  prod_next;
  logic [ProdW-1:0]  thr;
  logic [SumW-1:0]   sum_next;
  logic [CountW-1:0] size_next;
  logic              close;
  logic              last;

  always_comb begin
    sum_next  = sum + {{(SumW-SampleW){1'b0}}, sample};
    size_next = size + 1'b1;
    idx_next  = idx + 1'b1;
    prod_next = prod + {{(ProdW-CountW){1'b0}}, cfg.cnt};
    thr       = thr_acc + {{(ProdW-CountW){1'b0}}, cfg.len};
    close     = (prod_next >= thr);
    last      = (idx_next >= cfg.len);
    req.valid    = take && close;
    req.dividend = sum_next + {{(SumW-CountW+1){1'b0}}, size_next[CountW-1:1]};
    req.divisor  = size_next;
    req.last     = last;
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      idx     <= '0;
      prod    <= '0;
      thr_acc <= '0;
      sum     <= '0;
      size    <= '0;
    end else if (take) begin
      if (close && last) begin
        idx     <= '0;
        prod    <= '0;
        thr_acc <= '0;
        sum     <= '0;
        size    <= '0;
      end else if (close) begin
        idx     <= idx_next;
        prod    <= prod_next;
        thr_acc <= thr;
        sum     <= '0;
        size    <= '0;
      end else begin
        idx     <= idx_next;
        prod    <= prod_next;
        sum     <= sum_next;
        size    <= size_next;
      end
    end
  end

endmodule

@@ hw/rtl/bda_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on bda_pkg.
module bda_div (
  input  logic                        clk,
  input  logic                        rst,
  input  bda_pkg::div_req_t           req,
  input  logic                        take_result,
  output logic                        busy,
  output logic                        done,
  output logic [bda_pkg::SampleW-1:0] quotient,
  output logic                        last
);
  import bda_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } div_state_t;

  localparam int StepW = $clog2(SumW);

  div_state_t        state;
  logic [SumW-1:0]   q;
  logic [CountW-1:0] rem;
  logic [CountW-1:0] divisor;
  logic [StepW-1:0]  step;

  logic [CountW:0]   rem_shift;
  logic              fits;
  logic [CountW:0]   rem_sub;

  always_comb begin
    rem_shift = {rem, q[SumW-1]};
    fits      = (rem_shift >= {1'b0, divisor});
    rem_sub   = rem_shift - {1'b0, divisor};
  end

  assign busy     = (state != S_IDLE);
  assign done     = (state == S_DONE);
  assign quotient = q[SampleW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (step == '0) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (take_result) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && req.valid) begin
      q       <= req.dividend;
      rem     <= '0;
      divisor <= req.divisor;
      last    <= req.last;
      step    <= StepW'(SumW - 1);
    end else if (state == S_RUN) begin
      q    <= {q[SumW-2:0], fits};
      rem  <= fits ? rem_sub[CountW-1:0] : rem_shift[CountW-1:0];
      step <= step - 1'b1;
    end
  end

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for block_decimating_average: streams sample words, writes the
// config registers, also mid-block, and checks every average against an in-bench predictor.
// Depends on bda_pkg and the block_decimating_average RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bda_pkg::*;

  localparam int unsigned MaxBlock    = 255;
  localparam int unsigned CycleLimit  = 1000000;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned MaxPrinted  = 100;
  localparam logic [IndexW-1:0]  CfgSpare2 = 2'd2;
  localparam logic [IndexW-1:0]  CfgSpare3 = 2'd3;
  localparam logic [SampleW-1:0] SampleMax = '1;

  typedef struct packed {
    logic [SampleW-1:0] average;
    logic               block_last;
  } avg_word_t;

  typedef enum int unsigned {FillMax, FillZero, FillTiny, FillRandom} fill_t;

  logic               clk        = 1'b0;
  logic               rst        = 1'b1;
  logic               in_valid   = 1'b0;
  logic               in_stall;
  logic [SampleW-1:0] sample     = '0;
  logic               out_valid;
  logic               out_stall  = 1'b0;
  logic [SampleW-1:0] average;
  logic               block_last;
  logic               cfg_valid  = 1'b0;
  logic               cfg_ready;
  logic [IndexW-1:0]  cfg_index  = '0;
  logic [CountW-1:0]  cfg_data   = '0;

  // predictor state
  logic [CountW-1:0] cfg_len;
  logic [CountW-1:0] cfg_groups;
  logic [CountW-1:0] blk_index;
  logic [ProdW-1:0]  blk_product;
  logic [ProdW-1:0]  blk_threshold;
  logic [SumW-1:0]   grp_sum;
  logic [CountW-1:0] grp_size;
  avg_word_t         expected_avgs[$];
  avg_word_t         want_word;

  int          send_idle_pct = 16;
  int          recv_idle_pct = 88;
  int unsigned cycle_count   = 0;
  int unsigned mismatches    = 0;
  int unsigned items_sent    = 0;
  int unsigned avgs_checked  = 0;
  int unsigned reg_writes    = 0;

  block_decimating_average #(.MAX_BLOCK(MaxBlock)) u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .sample     (sample),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .average    (average),
    .block_last (block_last),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles, %0d averages outstanding",
               cycle_count, expected_avgs.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  function automatic int unsigned block_len();
    if (cfg_len == 0) return 1;
    return (cfg_len > MaxBlock) ? MaxBlock : cfg_len;
  endfunction

  function automatic int unsigned groups_per_block();
    int unsigned c;
    c = (cfg_groups == 0) ? 1 : cfg_groups;
    return (c > block_len()) ? block_len() : c;
  endfunction

  function automatic void restart_block();
    blk_index     = '0;
    blk_product   = '0;
    blk_threshold = ProdW'(block_len());
    grp_sum       = '0;
    grp_size      = '0;
  endfunction

  function automatic void apply_reg(input logic [IndexW-1:0] idx, input logic [CountW-1:0] val);
    if (idx == CfgSampleCount) begin
      cfg_len = val;
      restart_block();
    end else if (idx == CfgGroupCount) begin
      cfg_groups = val;
      restart_block();
    end
  endfunction

  function automatic void predict_average(input logic [SampleW-1:0] s);
    int unsigned len, cnt, sum_u, size_u;
    avg_word_t   w;
    len         = block_len();
    cnt         = groups_per_block();
    grp_sum     = grp_sum + SumW'(s);
    grp_size    = grp_size + 1'b1;
    blk_index   = blk_index + 1'b1;
    blk_product = blk_product + ProdW'(cnt);
    if (blk_product >= blk_threshold) begin
      sum_u        = grp_sum;
      size_u       = grp_size;
      w.average    = SampleW'((sum_u + size_u / 2) / size_u);
      w.block_last = (blk_index >= len);
      expected_avgs.push_back(w);
      if (w.block_last) begin
        restart_block();
      end else begin
        blk_threshold = blk_threshold + ProdW'(len);
        grp_sum       = '0;
        grp_size      = '0;
      end
    end
  endfunction

  function automatic logic [SampleW-1:0] pick_sample(input fill_t fill);
    case (fill)
      FillMax:  return SampleMax;
      FillZero: return '0;
      FillTiny: return SampleW'($urandom_range(3));
      default:  return SampleW'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MaxPrinted) $display("MISMATCH cycle %0d: %s", cycle_count, what);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      avgs_checked++;
      if (expected_avgs.size() == 0) begin
        report_mismatch($sformatf("average %0d last %0b with none expected",
                                  average, block_last));
      end else begin
        want_word = expected_avgs.pop_front();
        if (average !== want_word.average)
          report_mismatch($sformatf("average %0d, expected %0d", average, want_word.average));
        if (block_last !== want_word.block_last)
          report_mismatch($sformatf("block_last %0b, expected %0b (average %0d)",
                                    block_last, want_word.block_last, want_word.average));
      end
    end
  end

  task automatic send_sample(input logic [SampleW-1:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    predict_average(s);
  endtask

  // all averages out, then room for a sample that closes no group
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_avgs.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IndexW-1:0] idx, input logic [CountW-1:0] val);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    reg_writes++;
    apply_reg(idx, val);
  endtask

  task automatic test_reset_defaults();
    send_sample('0);
    send_sample(SampleMax);
    send_sample(15'h5555);
    send_sample(15'h2AAA);
  endtask

  task automatic test_rounding_and_groups();
    write_reg(CfgSampleCount, 8'd2);
    write_reg(CfgGroupCount, 8'd1);
    send_sample(15'd0);
    send_sample(15'd1);
    send_sample(SampleMax);
    send_sample(SampleMax - 1'b1);
    // uneven groups: 2, 1, 1
    write_reg(CfgSampleCount, 8'd4);
    write_reg(CfgGroupCount, 8'd3);
    send_sample(15'd3);
    send_sample(15'd4);
    send_sample(15'd7);
    send_sample(SampleMax);
  endtask

  task automatic test_register_corners();
    write_reg(CfgSampleCount, 8'd3);
    write_reg(CfgGroupCount, 8'd0);
    send_sample(15'd1);
    send_sample(15'd2);
    send_sample(15'd2);
    write_reg(CfgSampleCount, 8'd0);
    send_sample(15'd9);
    write_reg(CfgSampleCount, 8'd2);
    write_reg(CfgGroupCount, 8'd200);
    send_sample(15'd10);
    send_sample(15'd11);
    // spare indexes leave the open block alone
    write_reg(CfgGroupCount, 8'd1);
    send_sample(15'd100);
    write_reg(CfgSpare2, 8'hFF);
    write_reg(CfgSpare3, 8'h00);
    send_sample(15'd201);
    // a real write drops a half-filled block
    write_reg(CfgSampleCount, 8'd3);
    send_sample(SampleMax);
    send_sample(SampleMax);
    write_reg(CfgGroupCount, 8'd1);
    send_sample(15'd5);
    send_sample(15'd6);
    send_sample(15'd8);
  endtask

  task automatic test_largest_block();
    write_reg(CfgSampleCount, CountW'(MaxBlock));
    write_reg(CfgGroupCount, 8'd1);
    repeat (MaxBlock) send_sample(SampleMax);
  endtask

  task automatic test_random_blocks(input int send_pct, input int recv_pct,
                                    input int unsigned n_items);
    int unsigned goal, len_w, grp_w, eff, n_samples, r;
    fill_t       fill;
    goal          = items_sent + n_items;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    fill          = FillRandom;
    while (items_sent < goal) begin
      if ($urandom_range(31) == 0) len_w = MaxBlock;
      else if ($urandom_range(15) == 0) len_w = 0;
      else if ($urandom_range(7) == 0) len_w = $urandom_range(60, 13);
      else len_w = $urandom_range(12, 1);
      eff = (len_w == 0) ? 1 : len_w;
      case ($urandom_range(5))
        0:       grp_w = 0;
        1:       grp_w = $urandom_range(255, eff);
        2:       grp_w = eff;
        3:       grp_w = 1;
        default: grp_w = $urandom_range(eff, 1);
      endcase
      if ($urandom_range(9) == 0)
        write_reg($urandom_range(1) ? CfgSpare2 : CfgSpare3, CountW'($urandom));
      if ($urandom_range(1)) begin
        write_reg(CfgSampleCount, CountW'(len_w));
        write_reg(CfgGroupCount, CountW'(grp_w));
      end else begin
        write_reg(CfgGroupCount, CountW'(grp_w));
        write_reg(CfgSampleCount, CountW'(len_w));
      end
      n_samples = (eff > 32) ? eff : eff * $urandom_range(4, 1);
      if ($urandom_range(3) == 0) n_samples += $urandom_range(eff - 1, 0);
      for (int unsigned k = 0; k < n_samples; k++) begin
        if (k % eff == 0) begin
          r    = $urandom_range(7);
          fill = (r > 3) ? FillRandom : fill_t'(r);
        end
        send_sample(pick_sample(fill));
      end
    end
  endtask

  initial begin
    cfg_len    = 8'd1;
    cfg_groups = 8'd1;
    restart_block();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_rounding_and_groups();
    test_register_corners();
    test_largest_block();
    test_random_blocks(16, 88, 300);
    test_random_blocks(88, 16, 300);
    test_random_blocks(0, 0, 300);
    wait_drained();
    $display("Run covered %0d samples, %0d averages and %0d register writes,",
             items_sent, avgs_checked, reg_writes);
    $display("incl. rounding, count clamps, block restarts and three stall mixes.");
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
